// File: rtl/crtc_pkg.sv
`default_nettype none
package crtc_pkg;
  localparam int MAX_CUTS_DEF = 64;
  localparam logic [7:0] EDGE_MARGIN_RST = 8'd10;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_CHUNK  = 2'd1,
    OP_TICK   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  localparam logic CFG_LAST_CHUNK  = 1'b0;
  localparam logic CFG_EDGE_MARGIN = 1'b1;

  localparam logic [2:0] CLS_NORMAL = 3'd0;
  localparam logic [2:0] CLS_START  = 3'd1;
  localparam logic [2:0] CLS_STOP   = 3'd2;
  localparam logic [2:0] CLS_INSIDE = 3'd3;
  localparam logic [2:0] CLS_HEAD   = 3'd4;
  localparam logic [2:0] CLS_TAIL   = 3'd5;

  localparam logic [1:0] TS_NONE  = 2'd0;
  localparam logic [1:0] TS_BEGIN = 2'd1;
  localparam logic [1:0] TS_IN    = 2'd2;
  localparam logic [1:0] TS_END   = 2'd3;

  typedef struct packed {
    logic [31:0] start_chunk;
    logic [31:0] stop_chunk;
    logic [9:0]  start_record;
    logic [9:0]  stop_record;
    logic [32:0] start_time;
    logic [32:0] stop_time;
    logic        sos;
    logic        eos;
    logic        ast;
    logic        aen;
  } entry_t;

  // Token that travels along the chain with the query.
  typedef struct packed {
    logic        active;
    logic [1:0]  op;
    logic [32:0] key;
    logic        cls_done;
    logic [2:0]  cls;
    logic        rec_done;
    logic [9:0]  rec;
    logic        tick_done;
    logic [1:0]  tstat;
    logic [32:0] tval;
  } tok_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_SCAN = 2'd1,
    ST_OUT  = 2'd2
  } state_t;
endpackage
`default_nettype wire

// File: rtl/cut_range_table_classifier.sv
`default_nettype none
// Insert and clear present their result in the cycle after accept; chunk
// and tick queries first pass the token through all MAX_CUTS cells of the
// entry chain, one cell per cycle. One item in flight: the input reopens in
// the cycle after the result beat is taken.
// Reset (synchronous, rst_n low) empties the table and restores
// last_chunk = 0, edge_margin = 10; entry contents are not cleared.
module cut_range_table_classifier
  import crtc_pkg::*;
#(
  parameter int MAX_CUTS = MAX_CUTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_op,
  input  wire logic [31:0] in_start_chunk,
  input  wire logic [9:0]  in_start_record,
  input  wire logic [32:0] in_start_time,
  input  wire logic [31:0] in_stop_chunk,
  input  wire logic [9:0]  in_stop_record,
  input  wire logic [32:0] in_stop_time,
  input  wire logic [31:0] in_query_chunk,
  input  wire logic [32:0] in_query_ticks,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_chunk_class,
  output logic             out_record_found,
  output logic [9:0]       out_record_number,
  output logic [1:0]       out_tick_status,
  output logic [32:0]      out_tick_value,
  output logic             out_table_full,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data
);
  localparam int CW = $clog2(MAX_CUTS + 1);
  localparam int IW = (MAX_CUTS > 1) ? $clog2(MAX_CUTS) : 1;
  localparam int TW = $clog2(MAX_CUTS + 2);

  state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [TW-1:0] timer_r, timer_nxt;
  logic [31:0]   last_chunk_r;
  logic [7:0]    margin_r;
  logic          accept, scan_op;
  logic          res_load;
  tok_t          res_r, res_nxt;
  logic          full_r, full_nxt;
  entry_t        new_e;
  tok_t          head_tok;
  tok_t          chain [MAX_CUTS+1];
  logic [32:0]   diff;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign scan_op   = (in_op == OP_CHUNK) || (in_op == OP_TICK);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_chunk_r <= 32'd0;
      margin_r     <= EDGE_MARGIN_RST;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_LAST_CHUNK) last_chunk_r <= cfg_data;
      else margin_r <= cfg_data[7:0];
    end
  end

  // Signed difference last_chunk - stop_chunk in 33 bits.
  assign diff = {1'b0, last_chunk_r} - {1'b0, in_stop_chunk};

  always_comb begin
    new_e.start_chunk  = in_start_chunk;
    new_e.stop_chunk   = in_stop_chunk;
    new_e.start_record = in_start_record;
    new_e.stop_record  = in_stop_record;
    new_e.start_time   = in_start_time;
    new_e.stop_time    = in_stop_time;
    new_e.sos          = (in_start_chunk <= {24'd0, margin_r});
    new_e.eos          = diff[32] || (diff[31:0] <= {24'd0, margin_r});
    new_e.ast          = 1'b0;
    new_e.aen          = 1'b0;
  end

  // Inject the query token at the head of the chain.
  always_comb begin
    head_tok = '0;
    head_tok.active = accept && scan_op;
    head_tok.op     = in_op;
    head_tok.key    = (in_op == OP_TICK) ? in_query_ticks : {1'b0, in_query_chunk};
  end

  assign chain[0] = head_tok;

  genvar g;
  generate
    for (g = 0; g < MAX_CUTS; g++) begin : g_cell
      crtc_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (accept && in_op == OP_INSERT && count_r < CW'(MAX_CUTS) &&
                   count_r[IW-1:0] == IW'(g)),
        .wr_entry (new_e),
        .valid    (count_r > CW'(g)),
        .tok_in   (chain[g]),
        .tok_out  (chain[g+1])
      );
    end
  endgenerate

  // Next state.
  always_comb begin
    state_nxt = state_r;
    timer_nxt = timer_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = scan_op ? ST_SCAN : ST_OUT;
          timer_nxt = TW'(MAX_CUTS);
        end
      end
      ST_SCAN: begin
        timer_nxt = timer_r - TW'(1);
        if (timer_r == TW'(1)) state_nxt = ST_OUT;
      end
      ST_OUT: if (out_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Table count, full flag and result capture.
  always_comb begin
    count_nxt = count_r;
    full_nxt  = full_r;
    res_nxt   = res_r;
    res_load  = 1'b0;
    if (accept) begin
      full_nxt = 1'b0;
      res_nxt  = '0;
      res_load = 1'b1;
      case (in_op)
        OP_INSERT: begin
          if (count_r >= CW'(MAX_CUTS)) full_nxt = 1'b1;
          else count_nxt = count_r + CW'(1);
        end
        OP_CLEAR: count_nxt = '0;
        default: ;
      endcase
    end else if (state_r == ST_SCAN && timer_r == TW'(1)) begin
      res_nxt  = chain[MAX_CUTS];
      res_load = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      timer_r <= '0;
      full_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      timer_r <= timer_nxt;
      full_r  <= full_nxt;
    end
    if (res_load) res_r <= res_nxt;
  end

  // Outputs.
  always_comb begin
    out_valid         = (state_r == ST_OUT);
    out_chunk_class   = (res_r.op == OP_CHUNK && res_r.cls_done) ? res_r.cls : CLS_NORMAL;
    out_record_found  = (res_r.op == OP_CHUNK) && res_r.rec_done;
    out_record_number = out_record_found ? res_r.rec : 10'd0;
    out_tick_status   = (res_r.op == OP_TICK) ? res_r.tstat : TS_NONE;
    out_tick_value    = (res_r.op == OP_TICK) ? res_r.tval : 33'd0;
    out_table_full    = full_r;
  end
endmodule
`default_nettype wire

// File: rtl/crtc_cell.sv
`default_nettype none
module crtc_cell
  import crtc_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   wr_en,
  input  wire entry_t wr_entry,
  input  wire logic   valid,
  input  wire tok_t   tok_in,
  output tok_t        tok_out
);
  entry_t e_r;
  tok_t   tok_r;
  tok_t   t;
  logic [31:0] q;
  logic        ast_set, aen_set;

  always_comb begin
    t = tok_in;
    q = tok_in.key[31:0];
    ast_set = 1'b0;
    aen_set = 1'b0;
    if (tok_in.active && valid) begin
      if (tok_in.op == OP_CHUNK) begin
        if (!t.cls_done) begin
          t.cls_done = 1'b1;
          if (e_r.sos && q <= e_r.stop_chunk)
            t.cls = (e_r.stop_chunk == 32'd0 || q == e_r.stop_chunk - 32'd1) ?
                    CLS_NORMAL : CLS_HEAD;
          else if (e_r.eos && q > e_r.start_chunk) t.cls = CLS_TAIL;
          else if (e_r.start_chunk < q && e_r.stop_chunk > q) t.cls = CLS_INSIDE;
          else if (e_r.start_chunk == q) t.cls = CLS_START;
          else if (e_r.stop_chunk == q) t.cls = CLS_STOP;
          else t.cls_done = 1'b0;
        end
        if (!t.rec_done) begin
          if (e_r.start_chunk == q) begin
            t.rec_done = 1'b1;
            t.rec = e_r.start_record;
          end else if (e_r.stop_chunk == q) begin
            t.rec_done = 1'b1;
            t.rec = e_r.stop_record;
          end
        end
      end else if (tok_in.op == OP_TICK && !t.tick_done) begin
        if (e_r.start_time <= tok_in.key && e_r.stop_time > tok_in.key) begin
          t.tick_done = 1'b1;
          if (!e_r.sos) begin
            if (!e_r.ast) begin
              ast_set = 1'b1;
              t.tstat = TS_BEGIN;
              t.tval = e_r.start_time;
            end else begin
              t.tstat = TS_IN;
            end
          end
        end else if (e_r.stop_time < tok_in.key && !e_r.aen && e_r.ast) begin
          t.tick_done = 1'b1;
          aen_set = 1'b1;
          t.tstat = TS_END;
          t.tval = e_r.stop_time;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      e_r <= wr_entry;
    end else begin
      if (ast_set) e_r.ast <= 1'b1;
      if (aen_set) e_r.aen <= 1'b1;
    end
    tok_r <= t;
    if (!rst_n) tok_r.active <= 1'b0;
  end

  assign tok_out = tok_r;
endmodule
`default_nettype wire
